FILE: rtl/core/ukv_pkg.sv
package ukv_pkg;

    // Table geometry.
    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Width of the microprogram counter.
    localparam int UPC_W = 5;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        REQ_INSERT,
        REQ_ERASE_KEY,
        REQ_ERASE_SLOT,
        REQ_LOOKUP
    } req_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DUPLICATE,
        ST_NOT_FOUND,
        ST_FULL
    } status_t;

    // Sequencing of the microprogram.
    typedef enum logic [2:0] {
        BR_NEXT,      // go to the following step
        BR_JUMP,      // go to the target
        BR_COND,      // target when the condition holds, else the following step
        BR_LOOP,      // target when the condition holds, else repeat this step
        BR_DISPATCH   // on a new transaction go to its handler, else wait here
    } branch_t;

    typedef enum logic [2:0] {
        C_END,
        C_END_OR_MATCH,
        C_IN_USE,
        C_LAST,
        C_FULL,
        C_IS_INSERT,
        C_IS_LOOKUP,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_LOAD,   // zero, or the requested slot for an erase by slot
        IDX_STEP    // advance while a loop step repeats
    } idx_op_t;

    typedef enum logic {
        RD_CUR,     // read the entry the index will point at
        RD_AHEAD    // read the entry one past it
    } rd_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_SHIFT,
        ACT_SHRINK,
        ACT_DUP,
        ACT_NOTF,
        ACT_FULL,
        ACT_LHIT,
        ACT_ERASE,
        ACT_POST
    } act_t;

    typedef struct packed {
        logic    accept;
        branch_t br;
        cond_t   cond;
        upc_t    target;
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        act_t    act;
    } ucw_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic    start;
        logic    cond_true;
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        act_t    act;
    } ukv_ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic at_end;
        logic key_match;
        logic last;
        logic full;
        logic is_insert;
        logic is_lookup;
        logic out_free;
    } ukv_flags_t;

    // Microprogram addresses.
    localparam upc_t U_IDLE     = UPC_W'(0);
    localparam upc_t U_SEARCH   = UPC_W'(1);
    localparam upc_t U_SPLIT    = UPC_W'(2);
    localparam upc_t U_FOUND    = UPC_W'(3);
    localparam upc_t U_FOUND2   = UPC_W'(4);
    localparam upc_t U_ERASE    = UPC_W'(5);
    localparam upc_t U_SHIFT    = UPC_W'(6);
    localparam upc_t U_SHRINK   = UPC_W'(7);
    localparam upc_t U_SLOT_CHK = UPC_W'(8);
    localparam upc_t U_MISS     = UPC_W'(9);
    localparam upc_t U_NOTF     = UPC_W'(10);
    localparam upc_t U_INS_CHK  = UPC_W'(11);
    localparam upc_t U_INS_DO   = UPC_W'(12);
    localparam upc_t U_FULL     = UPC_W'(13);
    localparam upc_t U_DUP      = UPC_W'(14);
    localparam upc_t U_LHIT     = UPC_W'(15);
    localparam upc_t U_POST     = UPC_W'(16);

    function automatic ucw_t uw(input logic accept, input branch_t br, input cond_t cond,
                                input upc_t target, input idx_op_t idx_op,
                                input rd_sel_t rd_sel, input act_t act);
        return '{accept, br, cond, target, idx_op, rd_sel, act};
    endfunction

    // The microprogram ROM.
    function automatic ucw_t ukv_ucode(input upc_t upc);
        ucw_t cw;
        case (upc)
            U_IDLE:     cw = uw(1'b1, BR_DISPATCH, C_END, U_IDLE, IDX_LOAD, RD_CUR, ACT_NONE);
            U_SEARCH:   cw = uw(1'b0, BR_LOOP, C_END_OR_MATCH, U_SPLIT, IDX_STEP, RD_CUR,
                                ACT_NONE);
            U_SPLIT:    cw = uw(1'b0, BR_COND, C_END, U_MISS, IDX_HOLD, RD_CUR, ACT_NONE);
            U_FOUND:    cw = uw(1'b0, BR_COND, C_IS_INSERT, U_DUP, IDX_HOLD, RD_CUR, ACT_NONE);
            U_FOUND2:   cw = uw(1'b0, BR_COND, C_IS_LOOKUP, U_LHIT, IDX_HOLD, RD_CUR, ACT_NONE);
            U_ERASE:    cw = uw(1'b0, BR_NEXT, C_END, U_IDLE, IDX_HOLD, RD_AHEAD, ACT_ERASE);
            U_SHIFT:    cw = uw(1'b0, BR_LOOP, C_LAST, U_SHRINK, IDX_STEP, RD_AHEAD, ACT_SHIFT);
            U_SHRINK:   cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_SHRINK);
            U_SLOT_CHK: cw = uw(1'b0, BR_COND, C_IN_USE, U_ERASE, IDX_HOLD, RD_CUR, ACT_NONE);
            U_MISS:     cw = uw(1'b0, BR_COND, C_IS_INSERT, U_INS_CHK, IDX_HOLD, RD_CUR,
                                ACT_NONE);
            U_NOTF:     cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_NOTF);
            U_INS_CHK:  cw = uw(1'b0, BR_COND, C_FULL, U_FULL, IDX_HOLD, RD_CUR, ACT_NONE);
            U_INS_DO:   cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_APPEND);
            U_FULL:     cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_FULL);
            U_DUP:      cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_DUP);
            U_LHIT:     cw = uw(1'b0, BR_JUMP, C_END, U_POST, IDX_HOLD, RD_CUR, ACT_LHIT);
            U_POST:     cw = uw(1'b0, BR_LOOP, C_OUT_FREE, U_IDLE, IDX_HOLD, RD_CUR, ACT_POST);
            default:    cw = uw(1'b0, BR_JUMP, C_END, U_IDLE, IDX_HOLD, RD_CUR, ACT_NONE);
        endcase
        return cw;
    endfunction

    // Entry point of the handler for each request type.
    function automatic upc_t ukv_dispatch(input req_t req);
        upc_t target;
        case (req)
            REQ_ERASE_SLOT: target = U_SLOT_CHK;
            default:        target = U_SEARCH;
        endcase
        return target;
    endfunction

endpackage

FILE: rtl/core/ukv_sequencer.sv
module ukv_sequencer
    import ukv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_req_type,
    input  ukv_flags_t flags,
    output logic       s_ready,
    output ukv_ctl_t   ctl
);

    upc_t upc_reg;
    upc_t upc_next;
    ucw_t cw;
    logic cond_true;

    assign cw = ukv_ucode(upc_reg);

    always_comb begin
        case (cw.cond)
            C_END:          cond_true = flags.at_end;
            C_END_OR_MATCH: cond_true = flags.at_end | flags.key_match;
            C_IN_USE:       cond_true = ~flags.at_end;
            C_LAST:         cond_true = flags.last;
            C_FULL:         cond_true = flags.full;
            C_IS_INSERT:    cond_true = flags.is_insert;
            C_IS_LOOKUP:    cond_true = flags.is_lookup;
            C_OUT_FREE:     cond_true = flags.out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        case (cw.br)
            BR_NEXT:     upc_next = upc_reg + UPC_W'(1);
            BR_JUMP:     upc_next = cw.target;
            BR_COND:     upc_next = cond_true ? cw.target : upc_reg + UPC_W'(1);
            BR_LOOP:     upc_next = cond_true ? cw.target : upc_reg;
            BR_DISPATCH: upc_next = s_valid ? ukv_dispatch(req_t'(s_req_type)) : upc_reg;
            default:     upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign s_ready       = cw.accept;
    assign ctl.start     = cw.accept & s_valid;
    assign ctl.cond_true = cond_true;
    assign ctl.idx_op    = cw.idx_op;
    assign ctl.rd_sel    = cw.rd_sel;
    assign ctl.act       = cw.act;

endmodule

FILE: rtl/core/ukv_datapath.sv
module ukv_datapath
    import ukv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ukv_ctl_t          ctl,
    input  logic [1:0]        s_req_type,
    input  logic [31:0]       s_key_in,
    input  logic [31:0]       s_value_in,
    input  logic [SLOT_W-1:0] s_slot_in,
    input  logic              m_ready,
    output ukv_flags_t        flags,
    output logic              m_valid,
    output logic [1:0]        m_status,
    output logic              m_hit,
    output logic [SLOT_W-1:0] m_slot_out,
    output logic [31:0]       m_value_out,
    output logic [CNT_W-1:0]  m_entries_used
);

    logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

    req_t                   req_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [CNT_W-1:0]       ahead_idx;
    logic [SLOT_W-1:0]      rd_addr;

    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_val;

    status_t                rs_status_reg, rs_status_next;
    logic                   rs_hit_reg, rs_hit_next;
    logic [SLOT_W-1:0]      rs_slot_reg, rs_slot_next;
    logic [VALUE_WIDTH-1:0] rs_value_reg, rs_value_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg;
    logic                   m_hit_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic [VALUE_WIDTH-1:0] m_value_reg;
    logic [CNT_W-1:0]       m_used_reg;
    logic                   post;
    logic [CNT_W:0]         idx_plus1;

    assign post      = (ctl.act == ACT_POST) & ctl.cond_true;
    assign idx_plus1 = {1'b0, idx_reg} + (CNT_W + 1)'(1);

    assign flags.at_end    = idx_reg >= used_reg;
    assign flags.key_match = rd_key_reg == key_reg;
    assign flags.last      = idx_plus1 >= {1'b0, used_reg};
    assign flags.full      = used_reg == CNT_W'(DEPTH);
    assign flags.is_insert = req_reg == REQ_INSERT;
    assign flags.is_lookup = req_reg == REQ_LOOKUP;
    assign flags.out_free  = ~m_valid_reg | m_ready;

    always_comb begin
        case (ctl.idx_op)
            IDX_LOAD: begin
                if (ctl.start) begin
                    idx_next = (req_t'(s_req_type) == REQ_ERASE_SLOT) ?
                               CNT_W'(s_slot_in) : '0;
                end else begin
                    idx_next = idx_reg;
                end
            end
            IDX_STEP: idx_next = ctl.cond_true ? idx_reg : idx_reg + CNT_W'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    // The read address follows the next index so the registered read data
    // always belongs to the entry the index points at (or the one after it).
    assign ahead_idx = idx_next + CNT_W'(1);
    assign rd_addr   = (ctl.rd_sel == RD_AHEAD) ? ahead_idx[SLOT_W-1:0] :
                                                  idx_next[SLOT_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[SLOT_W-1:0];
        wr_key  = rd_key_reg;
        wr_val  = rd_val_reg;
        case (ctl.act)
            ACT_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = used_reg[SLOT_W-1:0];
                wr_key  = key_reg;
                wr_val  = val_reg;
            end
            ACT_SHIFT: wr_en = ~ctl.cond_true;
            default:   wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_comb begin
        used_next      = used_reg;
        rs_status_next = rs_status_reg;
        rs_hit_next    = rs_hit_reg;
        rs_slot_next   = rs_slot_reg;
        rs_value_next  = rs_value_reg;
        case (ctl.act)
            ACT_APPEND: begin
                used_next      = used_reg + CNT_W'(1);
                rs_status_next = ST_OK;
                rs_hit_next    = 1'b0;
                rs_slot_next   = used_reg[SLOT_W-1:0];
                rs_value_next  = '0;
            end
            ACT_SHRINK: used_next = used_reg - CNT_W'(1);
            ACT_DUP: begin
                rs_status_next = ST_DUPLICATE;
                rs_hit_next    = 1'b0;
                rs_slot_next   = idx_reg[SLOT_W-1:0];
                rs_value_next  = '0;
            end
            ACT_NOTF: begin
                rs_status_next = ST_NOT_FOUND;
                rs_hit_next    = 1'b0;
                rs_slot_next   = '0;
                rs_value_next  = '0;
            end
            ACT_FULL: begin
                rs_status_next = ST_FULL;
                rs_hit_next    = 1'b0;
                rs_slot_next   = '0;
                rs_value_next  = '0;
            end
            ACT_LHIT: begin
                rs_status_next = ST_OK;
                rs_hit_next    = 1'b1;
                rs_slot_next   = idx_reg[SLOT_W-1:0];
                rs_value_next  = rd_val_reg;
            end
            ACT_ERASE: begin
                rs_status_next = ST_OK;
                rs_hit_next    = 1'b1;
                rs_slot_next   = idx_reg[SLOT_W-1:0];
                rs_value_next  = '0;
            end
            default: used_next = used_reg;
        endcase
    end

    always_comb begin
        if (post) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            req_reg <= req_t'(s_req_type);
            key_reg <= s_key_in[KEY_WIDTH-1:0];
            val_reg <= s_value_in[VALUE_WIDTH-1:0];
        end
        rs_status_reg <= rs_status_next;
        rs_hit_reg    <= rs_hit_next;
        rs_slot_reg   <= rs_slot_next;
        rs_value_reg  <= rs_value_next;
        if (post) begin
            m_status_reg <= rs_status_reg;
            m_hit_reg    <= rs_hit_reg;
            m_slot_reg   <= rs_slot_reg;
            m_value_reg  <= rs_value_reg;
            m_used_reg   <= used_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_hit          = m_hit_reg;
    assign m_slot_out     = m_slot_reg;
    assign m_value_out    = m_value_reg;
    assign m_entries_used = m_used_reg;

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds table depth");

    a_append_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.act == ACT_APPEND |-> used_reg < CNT_W'(DEPTH))
        else $error("append into a full table");

    a_hit_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_hit_reg |-> m_status_reg == ST_OK)
        else $error("hit reported with a failing status");

    a_value_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_hit_reg |-> m_value_reg == '0)
        else $error("nonzero value without a hit");

endmodule

FILE: rtl/core/unsorted_key_value_table.sv
// Throughput: one transaction at a time; the next is taken once the previous result has
// been posted to the output register, which may still be waiting for m_ready.
// Reset (aresetn low, synchronous) empties the table and returns the sequencer to idle;
// the key and value memories keep whatever they held, and entries past the fill count never reach a result.
module unsorted_key_value_table
    import ukv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_key_in,
    input  logic [31:0] s_value_in,
    input  logic [3:0]  s_slot_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_hit,
    output logic [3:0]  m_slot_out,
    output logic [31:0] m_value_out,
    output logic [4:0]  m_entries_used
);

    // The sequencer steps through a small microprogram held in a constant ROM.
    // Each control word selects a branch type, a condition from the datapath,
    // an index operation, a read address mode and one datapath action.
    //
    // The datapath keeps the keys and values in two single-port-write memories
    // whose read data is registered. The read address is derived from the next
    // value of the scan index, so during a search each cycle compares one entry,
    // and during compaction each cycle moves one entry down by one slot.
    //
    // A search visits slots in order and stops at the first match or at the
    // fill count. An insert that misses appends at the fill count unless the
    // table is full. An erase primes a read one slot ahead, then copies each
    // following entry down before decrementing the fill count.
    //
    // The result is staged during the program and moved to the output register
    // in the final step, which waits only while an earlier result is still held.

    ukv_ctl_t   ctl;
    ukv_flags_t flags;

    ukv_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .flags      (flags),
        .s_ready    (s_ready),
        .ctl        (ctl)
    );

    ukv_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .s_req_type     (s_req_type),
        .s_key_in       (s_key_in),
        .s_value_in     (s_value_in),
        .s_slot_in      (s_slot_in),
        .m_ready        (m_ready),
        .flags          (flags),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_hit          (m_hit),
        .m_slot_out     (m_slot_out),
        .m_value_out    (m_value_out),
        .m_entries_used (m_entries_used)
    );

endmodule
